/* rtl/pie_pkg.sv */
// ----------------------------------------------------------------------------
// pie_pkg
// Shared types and constants of the power iteration eigenvector block.
// ----------------------------------------------------------------------------
package pie_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_VECTOR_LENGTH   = 2'd0;
  localparam logic [1:0] REG_ITERATION_COUNT = 2'd1;
  localparam int         CFG_IDX_W           = 2;
  localparam int         CFG_DATA_W          = 8;

  // register reset values
  localparam logic [4:0] VECTOR_LENGTH_RST   = 5'd16;
  localparam logic [7:0] ITERATION_COUNT_RST = 8'd20;

  // opcodes of an input word
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_START = 1'b1;

  // divide / square root unit widths
  localparam int DS_W     = 62;
  localparam int DS_REM_W = DS_W + 2;
  localparam int DS_DIV_W = 32;
  localparam int DS_CNT_W = 6;

  // input word
  typedef struct packed {
    logic               opcode;
    logic        [3:0]  row;
    logic        [3:0]  col;
    logic signed [31:0] element;
  } cmd_t;

  // result word
  typedef struct packed {
    logic        [3:0]  index;
    logic signed [31:0] component;
    logic               last;
    logic               zero_norm;
  } result_t;

  // request to the divide / square root unit
  typedef struct packed {
    logic go;
    logic sqrt_mode;
  } ds_cmd_t;

endpackage

/* rtl/pie_ram.sv */
// ----------------------------------------------------------------------------
// pie_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module pie_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/pie_divsqrt.sv */
// ----------------------------------------------------------------------------
// pie_divsqrt
// Shared restoring divider and digit-by-digit square root, one compare and
// subtract per cycle: DS_W steps to divide, DS_W/2 steps for a root.
// ----------------------------------------------------------------------------
module pie_divsqrt
  import pie_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  ds_cmd_t             cmd,
  input  logic [DS_W-1:0]     dividend,
  input  logic [DS_DIV_W-1:0] divisor,
  output logic                done,
  output logic [DS_W-1:0]     res
);

  logic [DS_W-1:0]     x;
  logic [DS_REM_W-1:0] rem;
  logic [DS_DIV_W-1:0] dvs;
  logic [DS_CNT_W-1:0] cnt;
  logic                mode;
  logic                busy;

  logic [DS_REM_W-1:0] cand;
  logic [DS_REM_W-1:0] trial;
  logic                ge;

  // one shared compare and subtract
  always_comb begin
    if (mode) begin
      cand  = {rem[DS_REM_W-3:0], x[DS_W-1:DS_W-2]};
      trial = {res, 2'b01};
    end else begin
      cand  = {rem[DS_REM_W-2:0], x[DS_W-1]};
      trial = DS_REM_W'(dvs);
    end
    ge = (cand >= trial);
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.go) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (cmd.go) begin
      x    <= dividend;
      dvs  <= divisor;
      rem  <= '0;
      res  <= '0;
      mode <= cmd.sqrt_mode;
      cnt  <= cmd.sqrt_mode ? DS_CNT_W'(DS_W / 2 - 1) : DS_CNT_W'(DS_W - 1);
    end else if (busy) begin
      rem <= ge ? cand - trial : cand;
      res <= {res[DS_W-2:0], ge};
      x   <= mode ? {x[DS_W-3:0], 2'b00} : {x[DS_W-2:0], 1'b0};
      cnt <= cnt - 1'b1;
    end
  end

endmodule

/* rtl/power_iteration_eigenvector.sv */
// ----------------------------------------------------------------------------
// power_iteration_eigenvector
// Dominant eigenvector of an n-by-n Q16.16 matrix by power iteration, with a
// shared multiplier and a shared divide / square root unit.
//
//   channel   handshake        payload               direction
//   command   start / busy     cmd (cmd_t)           in
//   result    strobe           result (result_t)     out
//   config    cfg_we           cfg_index, cfg_data   in
//
// A load word is taken while idle and the block stays ready.
// A start word keeps busy high through I iterations (s of 0..27 normalizing
//   shifts each; an iteration with a zero norm skips the shifts and divides),
// each with a multiply-accumulate per matrix entry and a 62-step divide per
// vector element in the divide / square root unit.
// Results are never strobed back to back; the receiver cannot stall them.
// Reset is synchronous; the matrix store is not cleared.
// ----------------------------------------------------------------------------
module power_iteration_eigenvector
  import pie_pkg::*;
#(
  parameter int MAX_LEN    = 16,
  parameter int ELEM_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  cmd_t                  cmd,
  output logic                  strobe,
  output result_t               result,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IW = $clog2(MAX_LEN);
  localparam int NW = $clog2(MAX_LEN + 1);
  localparam int AW = $clog2(MAX_LEN * MAX_LEN);

  // sequencer states
  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_DGO     = 5'd1;
  localparam logic [4:0] S_DWAIT   = 5'd2;
  localparam logic [4:0] S_SGO     = 5'd3;
  localparam logic [4:0] S_SWAIT   = 5'd4;
  localparam logic [4:0] S_FILL    = 5'd5;
  localparam logic [4:0] S_ITER    = 5'd6;
  localparam logic [4:0] S_MV_ADDR = 5'd7;
  localparam logic [4:0] S_MV_LOAD = 5'd8;
  localparam logic [4:0] S_MV_HI   = 5'd9;
  localparam logic [4:0] S_MV_LO   = 5'd10;
  localparam logic [4:0] S_MV_ACC  = 5'd11;
  localparam logic [4:0] S_MV_SAT  = 5'd12;
  localparam logic [4:0] S_NZ_CHK  = 5'd13;
  localparam logic [4:0] S_ZR_WR   = 5'd14;
  localparam logic [4:0] S_NZ_SH   = 5'd15;
  localparam logic [4:0] S_SC_ADDR = 5'd16;
  localparam logic [4:0] S_SC_LOAD = 5'd17;
  localparam logic [4:0] S_SC_SQ   = 5'd18;
  localparam logic [4:0] S_SC_ADD  = 5'd19;
  localparam logic [4:0] S_NR_GO   = 5'd20;
  localparam logic [4:0] S_NR_WAIT = 5'd21;
  localparam logic [4:0] S_DV_ADDR = 5'd22;
  localparam logic [4:0] S_DV_LOAD = 5'd23;
  localparam logic [4:0] S_DV_GO   = 5'd24;
  localparam logic [4:0] S_DV_WAIT = 5'd25;
  localparam logic [4:0] S_EM_ADDR = 5'd26;
  localparam logic [4:0] S_EM_OUT  = 5'd27;

  logic [4:0] state;
  logic [4:0] state_next;

  // configuration
  logic [4:0] vector_length;
  logic [7:0] iteration_count;

  // sequencer registers
  logic [IW-1:0]      i;
  logic [IW-1:0]      j;
  logic [IW-1:0]      n_m1;
  logic [7:0]         iter;
  logic               zero_norm_seen;
  logic [31:0]        fill_val;
  logic [DS_W-1:0]    quot;
  logic signed [47:0] mat_r;
  logic signed [31:0] v_r;
  logic signed [63:0] prod;
  logic signed [63:0] acc;
  logic [47:0]        max_mag;
  logic [47:0]        mt;
  logic signed [6:0]  sh;
  logic signed [28:0] z_r;
  logic [61:0]        sum;
  logic [30:0]        nrm;

  // memories
  logic                    mat_we;
  logic [AW-1:0]           mat_waddr;
  logic [AW-1:0]           mat_raddr;
  logic [ELEM_WIDTH-1:0]   mat_rdata;
  logic signed [ELEM_WIDTH-1:0] elem_sat;
  logic                    cv_we;
  logic [IW-1:0]           cv_raddr;
  logic [31:0]             cv_wdata;
  logic [31:0]             cv_rdata;
  logic                    nv_we;
  logic [47:0]             nv_wdata;
  logic [47:0]             nv_rdata;

  // shared units
  ds_cmd_t             ds_cmd;
  logic [DS_W-1:0]     ds_dividend;
  logic [DS_DIV_W-1:0] ds_divisor;
  logic                ds_done;
  logic [DS_W-1:0]     ds_res;
  logic signed [32:0]  mul_a;
  logic signed [31:0]  mul_b;
  logic signed [64:0]  mul_full;

  // misc combinational values
  logic               accept;
  logic [NW-1:0]      n_act;
  logic signed [47:0] sat;
  logic [47:0]        sat_mag;
  logic signed [47:0] z_full;
  logic [28:0]        z_mag;
  logic [DS_W-1:0]    dv_dividend;
  logic [31:0]        quo;
  logic signed [31:0] component;

  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      vector_length   <= VECTOR_LENGTH_RST;
      iteration_count <= ITERATION_COUNT_RST;
    end else if (cfg_we) begin
      if (cfg_index == REG_VECTOR_LENGTH) begin
        vector_length <= cfg_data[4:0];
      end else if (cfg_index == REG_ITERATION_COUNT) begin
        iteration_count <= cfg_data;
      end
    end
  end

  // active length, clamped to 1..MAX_LEN
  always_comb begin
    if (vector_length == '0) begin
      n_act = NW'(1);
    end else if (int'(vector_length) > MAX_LEN) begin
      n_act = NW'(MAX_LEN);
    end else begin
      n_act = NW'(vector_length);
    end
  end

  // element saturation for narrow matrix words
  generate
    if (ELEM_WIDTH < 32) begin : g_sat
      logic signed [31:0] hi_part;
      assign hi_part = cmd.element >>> (ELEM_WIDTH - 1);
      always_comb begin
        if (hi_part == '0 || hi_part == '1) begin
          elem_sat = cmd.element[ELEM_WIDTH-1:0];
        end else if (cmd.element[31]) begin
          elem_sat = {1'b1, {(ELEM_WIDTH-1){1'b0}}};
        end else begin
          elem_sat = {1'b0, {(ELEM_WIDTH-1){1'b1}}};
        end
      end
    end else begin : g_ext
      assign elem_sat = ELEM_WIDTH'($signed(cmd.element));
    end
  endgenerate

  // matrix store
  assign mat_we    = accept && cmd.opcode == OP_LOAD &&
                     int'(cmd.row) < MAX_LEN && int'(cmd.col) < MAX_LEN;
  assign mat_waddr = AW'(int'(cmd.row) * MAX_LEN + int'(cmd.col));
  assign mat_raddr = AW'(int'(i) * MAX_LEN + int'(j));

  pie_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(MAX_LEN * MAX_LEN)) u_mat (
    .clk   (clk),
    .we    (mat_we),
    .waddr (mat_waddr),
    .wdata (elem_sat),
    .raddr (mat_raddr),
    .rdata (mat_rdata)
  );

  // current vector, Q1.30
  assign cv_raddr = (state == S_EM_ADDR || state == S_EM_OUT) ? i : j;
  assign cv_we    = (state == S_FILL) || (state == S_ZR_WR) ||
                    (state == S_DV_WAIT && ds_done);
  always_comb begin
    unique case (state)
      S_FILL:  cv_wdata = fill_val;
      S_ZR_WR: cv_wdata = '0;
      default: cv_wdata = component;
    endcase
  end

  pie_ram #(.WIDTH(32), .DEPTH(MAX_LEN)) u_cv (
    .clk   (clk),
    .we    (cv_we),
    .waddr (i),
    .wdata (cv_wdata),
    .raddr (cv_raddr),
    .rdata (cv_rdata)
  );

  // product vector, then its scaled form
  assign nv_we    = (state == S_MV_SAT) || (state == S_SC_LOAD);
  assign nv_wdata = (state == S_MV_SAT) ? sat : 48'($signed(z_full[28:0]));

  pie_ram #(.WIDTH(48), .DEPTH(MAX_LEN)) u_nv (
    .clk   (clk),
    .we    (nv_we),
    .waddr (i),
    .wdata (nv_wdata),
    .raddr (i),
    .rdata (nv_rdata)
  );

  // saturate the row sum to 48 bits
  always_comb begin
    if (acc[63:47] == '0 || acc[63:47] == '1) begin
      sat = acc[47:0];
    end else if (acc[63]) begin
      sat = {1'b1, 47'd0};
    end else begin
      sat = {1'b0, {47{1'b1}}};
    end
    sat_mag = sat[47] ? 48'(-sat) : 48'(sat);
  end

  // scale so the largest magnitude has 28 bits
  always_comb begin
    if (sh > 0) begin
      z_full = $signed(nv_rdata) >>> 7'(sh);
    end else begin
      z_full = $signed(nv_rdata) <<< 7'(-sh);
    end
  end

  // rounded divide operands and signed quotient
  assign z_mag       = z_r[28] ? 29'(-z_r) : 29'(z_r);
  assign dv_dividend = DS_W'({z_mag, 30'd0}) + DS_W'(nrm >> 1);
  assign quo         = ds_res[31:0];
  assign component   = z_r[28] ? -$signed(quo) : $signed(quo);

  // shared multiplier operands
  always_comb begin
    unique case (state)
      S_MV_HI: begin
        mul_a = {mat_r[47], mat_r[47:16]};
        mul_b = v_r;
      end
      S_MV_LO: begin
        mul_a = {17'd0, mat_r[15:0]};
        mul_b = v_r;
      end
      default: begin
        mul_a = {{4{z_r[28]}}, z_r};
        mul_b = {{3{z_r[28]}}, z_r};
      end
    endcase
  end
  assign mul_full = mul_a * mul_b;

  // divide / square root requests
  assign ds_cmd.go        = (state == S_DGO) || (state == S_SGO) ||
                            (state == S_NR_GO) || (state == S_DV_GO);
  assign ds_cmd.sqrt_mode = (state == S_SGO) || (state == S_NR_GO);
  always_comb begin
    unique case (state)
      S_DGO: begin
        ds_dividend = DS_W'(1) << 60;
        ds_divisor  = DS_DIV_W'(n_m1) + 1'b1;
      end
      S_SGO: begin
        ds_dividend = quot;
        ds_divisor  = '0;
      end
      S_NR_GO: begin
        ds_dividend = sum;
        ds_divisor  = '0;
      end
      default: begin
        ds_dividend = dv_dividend;
        ds_divisor  = DS_DIV_W'(nrm);
      end
    endcase
  end

  pie_divsqrt u_ds (
    .clk      (clk),
    .rst      (rst),
    .cmd      (ds_cmd),
    .dividend (ds_dividend),
    .divisor  (ds_divisor),
    .done     (ds_done),
    .res      (ds_res)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:    if (accept && cmd.opcode == OP_START) state_next = S_DGO;
      S_DGO:     state_next = S_DWAIT;
      S_DWAIT:   if (ds_done) state_next = S_SGO;
      S_SGO:     state_next = S_SWAIT;
      S_SWAIT:   if (ds_done) state_next = S_FILL;
      S_FILL:    if (i == n_m1) state_next = S_ITER;
      S_ITER: begin
        state_next = (iter == iteration_count) ? S_EM_ADDR : S_MV_ADDR;
      end
      S_MV_ADDR: state_next = S_MV_LOAD;
      S_MV_LOAD: state_next = S_MV_HI;
      S_MV_HI:   state_next = S_MV_LO;
      S_MV_LO:   state_next = S_MV_ACC;
      S_MV_ACC:  state_next = (j == n_m1) ? S_MV_SAT : S_MV_ADDR;
      S_MV_SAT:  state_next = (i == n_m1) ? S_NZ_CHK : S_MV_ADDR;
      S_NZ_CHK:  state_next = (max_mag == '0) ? S_ZR_WR : S_NZ_SH;
      S_ZR_WR:   if (i == n_m1) state_next = S_ITER;
      S_NZ_SH: begin
        if (mt[47:28] == '0 && mt[27]) state_next = S_SC_ADDR;
      end
      S_SC_ADDR: state_next = S_SC_LOAD;
      S_SC_LOAD: state_next = S_SC_SQ;
      S_SC_SQ:   state_next = S_SC_ADD;
      S_SC_ADD:  state_next = (i == n_m1) ? S_NR_GO : S_SC_ADDR;
      S_NR_GO:   state_next = S_NR_WAIT;
      S_NR_WAIT: if (ds_done) state_next = S_DV_ADDR;
      S_DV_ADDR: state_next = S_DV_LOAD;
      S_DV_LOAD: state_next = S_DV_GO;
      S_DV_GO:   state_next = S_DV_WAIT;
      S_DV_WAIT: begin
        if (ds_done) state_next = (i == n_m1) ? S_ITER : S_DV_ADDR;
      end
      S_EM_ADDR: state_next = S_EM_OUT;
      S_EM_OUT:  state_next = (i == n_m1) ? S_IDLE : S_EM_ADDR;
      default:   state_next = S_IDLE;
    endcase
  end

  // state register and control counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      i              <= '0;
      j              <= '0;
      iter           <= '0;
      zero_norm_seen <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        S_IDLE: begin
          if (accept && cmd.opcode == OP_START) begin
            n_m1           <= IW'(n_act - 1'b1);
            iter           <= '0;
            zero_norm_seen <= 1'b0;
            i              <= '0;
          end
        end
        S_FILL, S_ZR_WR, S_EM_OUT: begin
          i <= (i == n_m1) ? '0 : i + 1'b1;
        end
        S_ITER: begin
          iter <= iter + 1'b1;
          i    <= '0;
          j    <= '0;
        end
        S_MV_ACC: begin
          j <= (j == n_m1) ? '0 : j + 1'b1;
        end
        S_MV_SAT: begin
          i <= (i == n_m1) ? '0 : i + 1'b1;
        end
        S_NZ_CHK: begin
          i <= '0;
          if (max_mag == '0) zero_norm_seen <= 1'b1;
        end
        S_SC_ADD: begin
          i <= (i == n_m1) ? '0 : i + 1'b1;
        end
        S_DV_WAIT: begin
          if (ds_done) i <= (i == n_m1) ? '0 : i + 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_DWAIT:   if (ds_done) quot <= ds_res;
      S_SWAIT:   if (ds_done) fill_val <= ds_res[31:0];
      S_ITER: begin
        acc     <= '0;
        max_mag <= '0;
      end
      S_MV_LOAD: begin
        mat_r <= 48'($signed(mat_rdata));
        v_r   <= cv_rdata;
      end
      S_MV_HI:   prod <= mul_full[63:0];
      S_MV_LO: begin
        acc  <= acc + prod;
        prod <= mul_full[63:0];
      end
      S_MV_ACC:  acc <= acc + (prod >>> 16);
      S_MV_SAT: begin
        acc <= '0;
        if (sat_mag > max_mag) max_mag <= sat_mag;
      end
      S_NZ_CHK: begin
        mt  <= max_mag;
        sh  <= '0;
        sum <= '0;
      end
      S_NZ_SH: begin
        if (mt[47:28] != '0) begin
          mt <= mt >> 1;
          sh <= sh + 1'b1;
        end else if (!mt[27]) begin
          mt <= mt << 1;
          sh <= sh - 1'b1;
        end
      end
      S_SC_LOAD: z_r <= z_full[28:0];
      S_SC_SQ:   prod <= mul_full[63:0];
      S_SC_ADD:  sum <= sum + prod[61:0];
      S_NR_WAIT: if (ds_done) nrm <= ds_res[30:0];
      S_DV_LOAD: z_r <= nv_rdata[28:0];
      default: begin
      end
    endcase
  end

  // result word
  assign strobe           = (state == S_EM_OUT);
  assign result.index     = 4'(i);
  assign result.component = cv_rdata;
  assign result.last      = (i == n_m1);
  assign result.zero_norm = zero_norm_seen;

  // checks
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> busy) else $error("result word outside a run");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd.opcode == OP_START) |=> busy) else $error("start not taken");

  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    (accept && cmd.opcode == OP_LOAD) |=> !busy) else $error("load left block busy");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.last) |=> !busy) else $error("run did not end on last");

  a_strobe_gap: assert property (@(posedge clk) disable iff (rst)
    strobe |=> !strobe) else $error("back to back result words");

endmodule
